// ===== rtl/gha_pkg.sv =====
package gha_pkg;

  // Pool size and field widths
  localparam int MAX_SLOTS = 1023;
  localparam int OWNER_BITS = 8;
  localparam int IDX_W = 10;
  localparam int GEN_W = 32;
  localparam int SLOT_AW = $clog2(MAX_SLOTS + 1);
  localparam int STACK_AW = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_SET     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_EXEC
  } state_t;

  // One slot table entry
  typedef struct packed {
    logic                  live;
    logic [GEN_W-1:0]      gen;
    logic [OWNER_BITS-1:0] owner;
  } slot_t;

  // Result item, status in the lowest bits
  typedef struct packed {
    logic [IDX_W-1:0]      active;
    logic [OWNER_BITS-1:0] owner;
    logic [GEN_W-1:0]      gen;
    logic [IDX_W-1:0]      index;
    status_t               status;
  } result_t;

  // Next generation; zero is skipped
  function automatic logic [GEN_W-1:0] bump_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = g + GEN_W'(1);
    return (n == '0) ? GEN_W'(1) : n;
  endfunction

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// Order: a granting acquire reads the free stack, then the slot table, then
//   executes (result and write-back); release, query and set owner read the
//   slot table, then execute; a full-pool acquire goes straight to execute.
//   One item is in flight at a time; a held result stalls the execute step.
// Reset: a clearing pass zeroes the slot table and refills the free stack;
//   s_tready stays low meanwhile.
module generational_handle_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // handle_index[9:0], handle_generation[41:10], owner_in[49:42], zero fill
  input  logic [55:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_status[1:0], result_index[11:2], result_generation[43:12],
  // result_owner[51:44], active_slots[61:52], zero fill
  output logic [63:0] m_tdata
);

  localparam int RES_W = $bits(gha_pkg::result_t);

  gha_pkg::state_t state, state_next;

  // Latched request
  gha_pkg::req_t                   req_q;
  logic [gha_pkg::IDX_W-1:0]       idx_q;
  logic [gha_pkg::GEN_W-1:0]       gen_q;
  logic [gha_pkg::OWNER_BITS-1:0]  own_q;
  logic                            full_q;

  logic [gha_pkg::CNT_W-1:0]       stack_depth;
  logic [gha_pkg::CNT_W-1:0]       active_total;
  logic [gha_pkg::SLOT_AW-1:0]     clr_cnt;

  // Memories
  logic [gha_pkg::IDX_W-1:0]       stack_mem [gha_pkg::MAX_SLOTS];
  gha_pkg::slot_t                  slot_mem  [gha_pkg::MAX_SLOTS + 1];
  logic [gha_pkg::IDX_W-1:0]       stack_q;
  gha_pkg::slot_t                  slot_q;

  logic                            stack_we, stack_re;
  logic [gha_pkg::STACK_AW-1:0]    stack_wa, stack_ra;
  logic [gha_pkg::IDX_W-1:0]       stack_wd;
  logic                            slot_we, slot_re;
  logic [gha_pkg::SLOT_AW-1:0]     slot_wa, slot_ra;
  gha_pkg::slot_t                  slot_wd;

  logic                            accept, exec_fire, clr_done, handle_ok;
  gha_pkg::result_t                res, res_next;
  logic [gha_pkg::CNT_W-1:0]       depth_next, active_next;
  logic                            do_write, do_push;
  gha_pkg::slot_t                  exec_wd;
  logic [gha_pkg::SLOT_AW-1:0]     exec_wa;
  gha_pkg::req_t                   in_req;

  assign in_req    = gha_pkg::req_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign clr_done  = (clr_cnt == gha_pkg::SLOT_AW'(gha_pkg::MAX_SLOTS));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      gha_pkg::ST_CLEAR: if (clr_done) state_next = gha_pkg::ST_IDLE;
      gha_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req == gha_pkg::REQ_ACQUIRE && stack_depth != '0)
            state_next = gha_pkg::ST_SLOT;
          else
            state_next = gha_pkg::ST_EXEC;
        end
      end
      gha_pkg::ST_SLOT: state_next = gha_pkg::ST_EXEC;
      gha_pkg::ST_EXEC: if (!m_tvalid || m_tready) state_next = gha_pkg::ST_IDLE;
      default: state_next = gha_pkg::ST_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_tready  = 1'b0;
    exec_fire = 1'b0;
    case (state)
      gha_pkg::ST_IDLE: s_tready  = 1'b1;
      gha_pkg::ST_EXEC: exec_fire = !m_tvalid || m_tready;
      default: begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= in_req;
      idx_q  <= s_tdata[9:0];
      gen_q  <= s_tdata[41:10];
      own_q  <= s_tdata[49:42];
      full_q <= (in_req == gha_pkg::REQ_ACQUIRE) && (stack_depth == '0);
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == gha_pkg::ST_CLEAR && !clr_done) begin
      clr_cnt <= clr_cnt + gha_pkg::SLOT_AW'(1);
    end
  end

  // Handle check against the slot entry read back
  assign handle_ok = (gen_q != '0) && (idx_q != '0)
                     && (32'(idx_q) <= gha_pkg::MAX_SLOTS)
                     && slot_q.live && (slot_q.gen == gen_q);

  // Execute step: result, write-back and counters
  always_comb begin
    res_next        = '0;
    res_next.status = gha_pkg::STAT_INVALID;
    res_next.index  = idx_q;
    depth_next      = stack_depth;
    active_next     = active_total;
    do_write        = 1'b0;
    do_push         = 1'b0;
    exec_wa         = gha_pkg::SLOT_AW'(idx_q);
    exec_wd         = slot_q;
    if (req_q == gha_pkg::REQ_ACQUIRE) begin
      if (full_q) begin
        res_next.status = gha_pkg::STAT_FULL;
        res_next.index  = '0;
      end else begin
        exec_wa         = gha_pkg::SLOT_AW'(stack_q);
        exec_wd.live    = 1'b1;
        exec_wd.gen     = gha_pkg::bump_gen(slot_q.gen);
        exec_wd.owner   = own_q;
        do_write        = 1'b1;
        depth_next      = stack_depth - gha_pkg::CNT_W'(1);
        active_next     = active_total + gha_pkg::CNT_W'(1);
        res_next.status = gha_pkg::STAT_OK;
        res_next.index  = stack_q;
        res_next.gen    = exec_wd.gen;
        res_next.owner  = own_q;
      end
    end else if (handle_ok) begin
      res_next.status = gha_pkg::STAT_OK;
      case (req_q)
        gha_pkg::REQ_RELEASE: begin
          exec_wd.live  = 1'b0;
          exec_wd.gen   = gha_pkg::bump_gen(slot_q.gen);
          exec_wd.owner = '0;
          do_write      = 1'b1;
          if (32'(stack_depth) < gha_pkg::MAX_SLOTS) begin
            do_push    = 1'b1;
            depth_next = stack_depth + gha_pkg::CNT_W'(1);
          end
          if (active_total != '0) active_next = active_total - gha_pkg::CNT_W'(1);
        end
        gha_pkg::REQ_QUERY: res_next.owner = slot_q.owner;
        gha_pkg::REQ_SET: begin
          exec_wd.owner  = own_q;
          do_write       = 1'b1;
          res_next.owner = own_q;
        end
        default: res_next.owner = '0;
      endcase
    end
    res_next.active = active_next;
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth  <= gha_pkg::CNT_W'(gha_pkg::MAX_SLOTS);
      active_total <= '0;
    end else if (exec_fire) begin
      stack_depth  <= depth_next;
      active_total <= active_next;
    end
  end

  // Free stack port control
  always_comb begin
    stack_re = accept && (in_req == gha_pkg::REQ_ACQUIRE) && (stack_depth != '0);
    stack_ra = gha_pkg::STACK_AW'(stack_depth - gha_pkg::CNT_W'(1));
    if (state == gha_pkg::ST_CLEAR) begin
      stack_we = (32'(clr_cnt) < gha_pkg::MAX_SLOTS);
      stack_wa = gha_pkg::STACK_AW'(clr_cnt);
      stack_wd = gha_pkg::IDX_W'(gha_pkg::MAX_SLOTS) - gha_pkg::IDX_W'(clr_cnt);
    end else begin
      stack_we = exec_fire && do_push;
      stack_wa = gha_pkg::STACK_AW'(stack_depth);
      stack_wd = idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (stack_re) stack_q <= stack_mem[stack_ra];
  end

  // Slot table port control
  always_comb begin
    slot_re = (accept && in_req != gha_pkg::REQ_ACQUIRE) || (state == gha_pkg::ST_SLOT);
    slot_ra = (state == gha_pkg::ST_SLOT) ? gha_pkg::SLOT_AW'(stack_q)
                                          : gha_pkg::SLOT_AW'(s_tdata[9:0]);
    if (state == gha_pkg::ST_CLEAR) begin
      slot_we = 1'b1;
      slot_wa = clr_cnt;
      slot_wd = '0;
    end else begin
      slot_we = exec_fire && do_write;
      slot_wa = exec_wa;
      slot_wd = exec_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_q <= slot_mem[slot_ra];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) res <= res_next;
  end

  assign m_tdata = {(64 - RES_W)'(0), res};

  // Assertions
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    32'(active_total) + 32'(stack_depth) == gha_pkg::MAX_SLOTS)
    else $error("live count and free stack depth disagree");

  a_full_means_all_live: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.status == gha_pkg::STAT_FULL)
      |-> (32'(res.active) == gha_pkg::MAX_SLOTS))
    else $error("pool full reported while slots are free");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && req_q == gha_pkg::REQ_ACQUIRE && !full_q)
      |=> (res.index != '0 && res.gen != '0))
    else $error("acquire granted reserved slot or zero generation");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item taken while one is in flight");

endmodule
